/* hw/rtl/brf_pkg.sv */
// Shared constants, opcodes and types for the bit ring FIFO.
package brf_pkg;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = 13;  // fill count and amount width
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_PEEK_AB = 3'd3,
    OP_SKIP    = 3'd4,
    OP_REWIND  = 3'd5,
    OP_RESET   = 3'd6,
    OP_NOP     = 3'd7
  } brf_op_t;

  // Request to the bit store: one write and one registered read per cycle.
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
  } brf_ram_req_t;

  // Status carried alongside a word until the read data returns.
  typedef struct packed {
    logic          rd_hit;
    logic [CW-1:0] fill_count;
    logic          overwrote;
  } brf_stat_t;

endpackage

/* hw/rtl/brf_if.sv */
// Valid/ready channel interfaces for the bit ring FIFO input and result words.
interface brf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic        bit_in;
  logic [12:0] amount;

  modport source (output valid, output opcode, output bit_in, output amount, input ready);
  modport sink   (input valid, input opcode, input bit_in, input amount, output ready);
endinterface

interface brf_out_if;
  logic        valid;
  logic        ready;
  logic        bit_out;
  logic [12:0] fill_count;
  logic        is_empty;
  logic        is_full;
  logic        overwrote;

  modport source (output valid, output bit_out, output fill_count, output is_empty,
                  output is_full, output overwrote, input ready);
  modport sink   (input valid, input bit_out, input fill_count, input is_empty,
                  input is_full, input overwrote, output ready);
endinterface

/* hw/rtl/brf_bit_ram.sv */
// Single-bit-wide bit store with one write port and one registered read port.
module brf_bit_ram
  import brf_pkg::*;
(
  input  logic         clk,
  input  brf_ram_req_t req,
  output logic         rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* hw/rtl/bit_ring_fifo_with_peek_rewind.sv */
// Bit ring FIFO with peek and rewind: top level.
// Pipeline: the bit store read (stage 1), then the output register.
// Throughput: one word per cycle while the result side keeps up; the bit store takes at most one access per word.
// Reset: pointers and count clear at once, then a clearing pass writes zeros over
// the 4096-entry bit store, one entry per cycle; no input word is taken until the
// pass finishes.
module bit_ring_fifo_with_peek_rewind
  import brf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch
);

  // Pointer and count state
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Stage 1: waiting on the bit store read
  logic          s1_valid_r;
  brf_stat_t     s1_stat_r, s1_stat_nxt;

  // Output register
  logic          out_valid_r;
  logic          out_bit_r;
  logic [CW-1:0] out_cnt_r;
  logic          out_ovw_r;

  logic          accept, s1_adv, in_ready;
  logic          ram_q;
  brf_ram_req_t  ram_req;
  brf_op_t       op;
  logic [AW-1:0] amt_lo;
  logic [CW-1:0] room;
  logic          rd_want;
  logic [AW-1:0] rd_addr;

  assign op     = brf_op_t'(in_ch.opcode);
  assign amt_lo = in_ch.amount[AW-1:0];
  assign room   = DEPTH_C - cnt_r;

  // Advance stage 1 into the output register whenever that register frees up.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Decode the word: pointer updates and which bit, if any, to read.
  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    cnt_nxt     = cnt_r;
    rd_want     = 1'b0;
    rd_addr     = rp_r;
    s1_stat_nxt = '0;
    unique case (op)
      OP_PUSH: begin
        wp_nxt = wp_r + 1'b1;
        if (cnt_r < DEPTH_C) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          // Full: drop the oldest bit.
          rp_nxt                = rp_r + 1'b1;
          s1_stat_nxt.overwrote = 1'b1;
        end
      end
      OP_POP: begin
        if (cnt_r != '0) begin
          rd_want = 1'b1;
          rd_addr = rp_r;
          rp_nxt  = rp_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_PEEK: begin
        if (in_ch.amount < cnt_r) begin
          rd_want = 1'b1;
          rd_addr = rp_r + amt_lo;
        end
      end
      OP_PEEK_AB: begin
        rd_want = 1'b1;
        rd_addr = amt_lo;
      end
      OP_SKIP: begin
        if (in_ch.amount >= cnt_r) begin
          rp_nxt  = wp_r;
          cnt_nxt = '0;
        end else begin
          rp_nxt  = rp_r + amt_lo;
          cnt_nxt = cnt_r - in_ch.amount;
        end
      end
      OP_REWIND: begin
        // Stepping back past the free room would cross unread data: empty instead.
        if (in_ch.amount > room) begin
          rp_nxt  = wp_r;
          cnt_nxt = '0;
        end else begin
          rp_nxt  = rp_r - amt_lo;
          cnt_nxt = cnt_r + in_ch.amount;
        end
      end
      OP_RESET: begin
        rp_nxt  = wp_r;
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
    s1_stat_nxt.rd_hit     = rd_want;
    s1_stat_nxt.fill_count = cnt_nxt;
  end

  // Bit store port: the clearing pass owns the write side until it finishes.
  always_comb begin
    ram_req = '0;
    if (clr_busy_r) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = clr_addr_r;
      ram_req.wr_data = 1'b0;
    end else begin
      ram_req.wr_en   = accept && (op == OP_PUSH);
      ram_req.wr_addr = wp_r;
      ram_req.wr_data = in_ch.bit_in;
    end
    // Read only on accept so the returned bit holds while stage 1 stalls.
    ram_req.rd_en   = accept && rd_want;
    ram_req.rd_addr = rd_addr;
  end

  brf_bit_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        wp_r  <= wp_nxt;
        rp_r  <= rp_nxt;
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= s1_stat_nxt;
    end
    if (s1_adv) begin
      out_bit_r <= s1_stat_r.rd_hit & ram_q;
      out_cnt_r <= s1_stat_r.fill_count;
      out_ovw_r <= s1_stat_r.overwrote;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bit_out    = out_bit_r;
  assign out_ch.fill_count = out_cnt_r;
  assign out_ch.is_empty   = (out_cnt_r == '0);
  assign out_ch.is_full    = (out_cnt_r == DEPTH_C);
  assign out_ch.overwrote  = out_ovw_r;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the bit ring FIFO with peek and rewind.
module tb_top;
  import brf_pkg::*;

  localparam int unsigned AMT_MAX      = (1 << CW) - 1;
  localparam int unsigned N_RANDOM     = 1130;
  localparam int unsigned GAP_MAX      = 12;
  localparam int unsigned DRAIN_CYCLES = 10;
  // Reset plus the store clearing pass, then every word at its worst gap and stall,
  // plus the long receiver hold, taken several times over.
  localparam int unsigned LIMIT_CYCLES = 400000;
  // Hold the receiver off once, long enough for the input side to back up.
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    brf_op_t       op;
    logic          b;
    logic [CW-1:0] amt;
  } op_word_t;

  typedef struct packed {
    logic          bit_out;
    logic [CW-1:0] fill_count;
    logic          is_empty;
    logic          is_full;
    logic          overwrote;
  } status_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();

  bit_ring_fifo_with_peek_rewind dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the FIFO: bit store, pointers and count.
  bit          shadow_bits [DEPTH];
  int unsigned shadow_wr;
  int unsigned shadow_rd;
  int unsigned shadow_held;

  op_word_t     op_words_q[$];        // words waiting to be offered
  status_word_t pending_status_q[$];  // status words the block still owes

  logic        in_hs  = 1'b0;  // handshake seen at the last rising edge
  logic        out_hs = 1'b0;
  int unsigned tx_count;
  int unsigned rx_count;
  int unsigned tx_gap;
  int unsigned rx_wait;
  int unsigned mismatches;
  int unsigned cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one operation to the shadow FIFO and return the status word it produces.
  function automatic status_word_t apply_fifo_op(op_word_t w);
    status_word_t s;
    s = '0;
    case (w.op)
      OP_PUSH: begin
        shadow_bits[AW'(shadow_wr)] = w.b;
        shadow_wr = (shadow_wr + 1) % DEPTH;
        if (shadow_held < DEPTH) begin
          shadow_held++;
        end else begin
          // Full: drop the oldest bit by advancing the read side.
          shadow_rd   = (shadow_rd + 1) % DEPTH;
          s.overwrote = 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_held != 0) begin
          s.bit_out = shadow_bits[AW'(shadow_rd)];
          shadow_rd = (shadow_rd + 1) % DEPTH;
          shadow_held--;
        end
      end
      OP_PEEK: begin
        if (w.amt < shadow_held)
          s.bit_out = shadow_bits[AW'((shadow_rd + w.amt) % DEPTH)];
      end
      OP_PEEK_AB: begin
        s.bit_out = shadow_bits[AW'(w.amt % DEPTH)];
      end
      OP_SKIP: begin
        if (w.amt >= shadow_held) begin
          shadow_rd   = shadow_wr;
          shadow_held = 0;
        end else begin
          shadow_rd   = (shadow_rd + w.amt) % DEPTH;
          shadow_held = shadow_held - w.amt;
        end
      end
      OP_REWIND: begin
        // Clear when stepping back past the free room, else re-expose consumed bits.
        if (w.amt > DEPTH - shadow_held) begin
          shadow_rd   = shadow_wr;
          shadow_held = 0;
        end else begin
          shadow_rd   = (shadow_rd + DEPTH - w.amt) % DEPTH;
          shadow_held = shadow_held + w.amt;
        end
      end
      OP_RESET: begin
        // Empty the FIFO; the bit store keeps its contents.
        shadow_rd   = shadow_wr;
        shadow_held = 0;
      end
      default: ;
    endcase
    s.fill_count = CW'(shadow_held);
    s.is_empty   = (shadow_held == 0);
    s.is_full    = (shadow_held == DEPTH);
    return s;
  endfunction

  task automatic queue_word(brf_op_t op, logic b, int unsigned amt);
    op_words_q.push_back('{op, b, CW'(amt)});
  endtask

  // Weight pushes and pops up so that the count wanders over the whole range.
  function automatic brf_op_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 32) return OP_PUSH;
    if (r < 48) return OP_POP;
    if (r < 61) return OP_PEEK;
    if (r < 71) return OP_PEEK_AB;
    if (r < 80) return OP_SKIP;
    if (r < 92) return OP_REWIND;
    if (r < 96) return OP_RESET;
    return OP_NOP;
  endfunction

  // Small amounts in four draws of ten; the rest spread out
  // over the whole field and cluster around the depth.
  function automatic int unsigned pick_amount();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 31);
      4, 5:       return $urandom_range(0, DEPTH);
      6:          return $urandom_range(DEPTH - 8, DEPTH + 8);
      7, 8:       return $urandom_range(0, AMT_MAX);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 0;
          1:       return DEPTH - 1;
          2:       return DEPTH;
          3:       return DEPTH + 1;
          default: return AMT_MAX;
        endcase
      end
    endcase
  endfunction

  // Predict on every accepted input word, then check every accepted result word.
  always @(posedge clk) begin
    op_word_t     w;
    status_word_t want;
    status_word_t got;
    in_hs  <= rst_n && in_ch.valid && in_ch.ready;
    out_hs <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.op  = brf_op_t'(in_ch.opcode);
      w.b   = in_ch.bit_in;
      w.amt = in_ch.amount;
      pending_status_q.push_back(apply_fifo_op(w));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_count++;
      got = '{out_ch.bit_out, out_ch.fill_count, out_ch.is_empty, out_ch.is_full,
              out_ch.overwrote};
      if (pending_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %0d: bit %0b count %0d", rx_count,
                   got.bit_out, got.fill_count);
      end else begin
        want = pending_status_q.pop_front();
        if (got.bit_out !== want.bit_out || got.fill_count !== want.fill_count ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
            got.overwrote !== want.overwrote) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch at result %0d: expected bit %0b count %0d empty %0b ",
                      "full %0b ovw %0b, got bit %0b count %0d empty %0b full %0b ovw %0b"},
                     rx_count, want.bit_out, want.fill_count, want.is_empty, want.is_full,
                     want.overwrote, got.bit_out, got.fill_count, got.is_empty,
                     got.is_full, got.overwrote);
        end
      end
    end
  end

  // Input driver: hold a word until taken, then wait out a drawn gap before the next.
  always @(negedge clk) begin
    op_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_hs) begin
      if (in_ch.valid) tx_count++;
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (op_words_q.size() != 0) begin
        w = op_words_q.pop_front();
        in_ch.opcode <= w.op;
        in_ch.bit_in <= w.b;
        in_ch.amount <= w.amt;
        in_ch.valid  <= 1'b1;
        // Every fourth stretch of 80 words goes back to back.
        tx_gap = ((tx_count / 80) % 4 == 1) ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each word taken, stall for a drawn wait.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.ready && out_hs) begin
        if (rx_count == HOLD_AT) rx_wait = HOLD_CYCLES;
        else if ((rx_count / 90) % 4 == 2) rx_wait = 0;
        else rx_wait = $urandom_range(0, GAP_MAX);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned run;
    brf_op_t     burst_op;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_NOP;
    in_ch.bit_in = 1'b0;
    in_ch.amount = '0;
    out_ch.ready = 1'b0;
    shadow_wr    = 0;
    shadow_rd    = 0;
    shadow_held  = 0;
    foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;

    // Directed part.
    queue_word(OP_PEEK_AB, 1'b0, 0);          // cleared store reads zero
    queue_word(OP_POP,     1'b1, 0);          // pop on empty: nothing changes
    queue_word(OP_PUSH,    1'b1, AMT_MAX);
    queue_word(OP_PUSH,    1'b0, 0);
    queue_word(OP_PUSH,    1'b1, 0);
    queue_word(OP_PEEK,    1'b0, 2);          // last held bit
    queue_word(OP_PEEK,    1'b0, 3);          // offset equal to count reads zero
    queue_word(OP_PEEK,    1'b1, AMT_MAX);
    queue_word(OP_POP,     1'b0, 0);
    queue_word(OP_SKIP,    1'b0, 1);
    queue_word(OP_SKIP,    1'b0, 1);          // skip exactly the count: empties
    queue_word(OP_REWIND,  1'b0, 3);          // re-expose the three pushed bits
    queue_word(OP_PEEK_AB, 1'b0, DEPTH + 2);  // position wraps modulo the depth
    queue_word(OP_PEEK_AB, 1'b1, AMT_MAX);
    queue_word(OP_NOP,     1'b1, AMT_MAX);
    queue_word(OP_RESET,   1'b1, AMT_MAX);
    queue_word(OP_REWIND,  1'b0, DEPTH);      // from empty straight to full
    queue_word(OP_PUSH,    1'b1, 0);          // push on full overwrites the oldest
    queue_word(OP_POP,     1'b0, 0);
    queue_word(OP_REWIND,  1'b0, 2);          // more than the free room: clears
    queue_word(OP_REWIND,  1'b0, DEPTH + 1);
    queue_word(OP_SKIP,    1'b0, 0);          // skip on empty
    queue_word(OP_REWIND,  1'b0, 0);
    queue_word(OP_PEEK,    1'b0, 0);          // peek on empty
    queue_word(OP_PEEK_AB, 1'b1, DEPTH - 1);

    // Random part: single operations mixed with runs of pushes or pops.
    for (int i = 0; i < N_RANDOM; ) begin
      if ($urandom_range(0, 9) == 0) begin
        run      = $urandom_range(8, 48);
        burst_op = ($urandom_range(0, 2) == 0) ? OP_POP : OP_PUSH;
        for (int k = 0; k < run && i < N_RANDOM; k++) begin
          queue_word(burst_op, 1'($urandom_range(0, 1)), pick_amount());
          i++;
        end
      end else begin
        queue_word(pick_op(), 1'($urandom_range(0, 1)), pick_amount());
        i++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: wait until every word is sent and every status word has come back.
    while (op_words_q.size() != 0 || in_ch.valid || pending_status_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/brf_pkg.sv
hw/rtl/brf_if.sv
hw/rtl/brf_bit_ram.sv
hw/rtl/bit_ring_fifo_with_peek_rewind.sv
tb/sv/tb_top.sv
